// ===== hw/rtl/vcvf_pkg.sv =====
// Shared constants, types and codes of the voxel component volume filter.
package vcvf_pkg;

  // Largest volume the block holds.
  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLUMNS = 64;
  localparam int MAX_SLICES  = 16;
  localparam int VOXEL_CAP   = MAX_ROWS * MAX_COLUMNS * MAX_SLICES;

  // Voxel address, and counts that must also hold the full capacity.
  localparam int IDX_W = (VOXEL_CAP > 1) ? $clog2(VOXEL_CAP) : 1;
  localparam int CNT_W = $clog2(VOXEL_CAP + 1);

  // Coordinate widths inside the volume.
  localparam int Y_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int X_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int Z_W = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;

  // Widths of the clamped dimensions.
  localparam int RDIM_W = $clog2(MAX_ROWS + 1);
  localparam int CDIM_W = $clog2(MAX_COLUMNS + 1);
  localparam int SDIM_W = $clog2(MAX_SLICES + 1);

  // Register and result field widths.
  localparam int ROW_REG_W  = 7;
  localparam int COL_REG_W  = 7;
  localparam int SLC_REG_W  = 5;
  localparam int THR_W      = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int SUM_W      = 17;
  localparam logic [SUM_W-1:0] SUM_LIMIT = '1;

  // Register reset values.
  localparam logic [ROW_REG_W-1:0] ROW_RESET = ROW_REG_W'(64);
  localparam logic [COL_REG_W-1:0] COL_RESET = COL_REG_W'(64);
  localparam logic [SLC_REG_W-1:0] SLC_RESET = SLC_REG_W'(16);
  localparam logic [THR_W-1:0]     THR_RESET = THR_W'(1);

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT,
    REG_COLUMN_COUNT,
    REG_SLICE_COUNT,
    REG_VOLUME_THRESHOLD
  } reg_index_t;

  // Neighbor directions, in the order they are probed.
  typedef enum logic [2:0] {
    DIR_Z_UP,
    DIR_Z_DOWN,
    DIR_X_UP,
    DIR_X_DOWN,
    DIR_Y_UP,
    DIR_Y_DOWN
  } dir_t;

  // One voxel position: linear address plus its coordinates.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [Z_W-1:0]   z;
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
  } entry_t;

  // Clamped dimensions with the derived plane size and voxel count.
  typedef struct packed {
    logic [RDIM_W-1:0] rows;
    logic [CDIM_W-1:0] cols;
    logic [SDIM_W-1:0] slices;
    logic [CNT_W-1:0]  plane;
    logic [CNT_W-1:0]  total;
  } dims_t;

endpackage

// ===== hw/rtl/vcvf_voxel_if.sv =====
// Input channel: one voxel bit per word.
interface vcvf_voxel_if;
  logic valid;
  logic ready;
  logic voxel_bit;

  modport source (output valid, output voxel_bit, input ready);
  modport sink (input valid, input voxel_bit, output ready);
endinterface

// ===== hw/rtl/vcvf_result_if.sv =====
// Output channel: one total volume per word.
interface vcvf_result_if;
  logic                       valid;
  logic                       ready;
  logic [vcvf_pkg::SUM_W-1:0] total_volume;

  modport source (output valid, output total_volume, input ready);
  modport sink (input valid, input total_volume, output ready);
endinterface

// ===== hw/rtl/vcvf_nbr.sv =====
// Neighbor generator: position, bounds check and address step for one direction.
module vcvf_nbr (
  input  vcvf_pkg::entry_t cur,
  input  vcvf_pkg::dir_t   dir,
  input  vcvf_pkg::dims_t  dims,
  output vcvf_pkg::entry_t nbr,
  output logic             ok
);

  logic [vcvf_pkg::CNT_W-1:0] z_up;
  logic [vcvf_pkg::CNT_W-1:0] x_up;
  logic [vcvf_pkg::CNT_W-1:0] y_up;

  // Coordinates one step up, widened so the compare against a dimension cannot wrap.
  assign z_up = vcvf_pkg::CNT_W'(cur.z) + vcvf_pkg::CNT_W'(1);
  assign x_up = vcvf_pkg::CNT_W'(cur.x) + vcvf_pkg::CNT_W'(1);
  assign y_up = vcvf_pkg::CNT_W'(cur.y) + vcvf_pkg::CNT_W'(1);

  // Step the address by one plane, one row or one column.
  always_comb begin
    nbr = cur;
    ok  = 1'b0;
    case (dir)
      vcvf_pkg::DIR_Z_UP: begin
        ok      = z_up < vcvf_pkg::CNT_W'(dims.slices);
        nbr.z   = cur.z + vcvf_pkg::Z_W'(1);
        nbr.idx = cur.idx + dims.plane[vcvf_pkg::IDX_W-1:0];
      end
      vcvf_pkg::DIR_Z_DOWN: begin
        ok      = cur.z != '0;
        nbr.z   = cur.z - vcvf_pkg::Z_W'(1);
        nbr.idx = cur.idx - dims.plane[vcvf_pkg::IDX_W-1:0];
      end
      vcvf_pkg::DIR_X_UP: begin
        ok      = x_up < vcvf_pkg::CNT_W'(dims.rows);
        nbr.x   = cur.x + vcvf_pkg::X_W'(1);
        nbr.idx = cur.idx + vcvf_pkg::IDX_W'(dims.cols);
      end
      vcvf_pkg::DIR_X_DOWN: begin
        ok      = cur.x != '0;
        nbr.x   = cur.x - vcvf_pkg::X_W'(1);
        nbr.idx = cur.idx - vcvf_pkg::IDX_W'(dims.cols);
      end
      vcvf_pkg::DIR_Y_UP: begin
        ok      = y_up < vcvf_pkg::CNT_W'(dims.cols);
        nbr.y   = cur.y + vcvf_pkg::Y_W'(1);
        nbr.idx = cur.idx + vcvf_pkg::IDX_W'(1);
      end
      vcvf_pkg::DIR_Y_DOWN: begin
        ok      = cur.y != '0;
        nbr.y   = cur.y - vcvf_pkg::Y_W'(1);
        nbr.idx = cur.idx - vcvf_pkg::IDX_W'(1);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/voxel_component_volume_filter.sv =====
// Loading takes one voxel word per cycle while input is not held off; the last voxel
// starts the fill phase. Fill: each voxel is scanned, a set voxel is pushed as a seed,
// each popped voxel probes its six neighbors and pushes the set ones, and each component
// is then closed, all through the single voxel memory port. The result waits while the
// previous total still waits. Synchronous reset restores the register defaults, empties
// the stack and restarts loading; any register write holds off input while dimensions
// settle.
module voxel_component_volume_filter (
  input  logic                            clk,
  input  logic                            rst,
  vcvf_voxel_if.sink                      voxel_in,
  vcvf_result_if.source                   result_out,
  input  logic                            cfg_write,
  input  logic [vcvf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vcvf_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_POP,
    ST_FETCH,
    ST_PROBE,
    ST_TEST,
    ST_AFTER,
    ST_COMP_END,
    ST_DONE
  } state_t;

  localparam logic [1:0] SETTLE_CYCLES = 2'd3;

  // Configuration registers.
  logic [vcvf_pkg::ROW_REG_W-1:0] row_reg;
  logic [vcvf_pkg::COL_REG_W-1:0] col_reg;
  logic [vcvf_pkg::SLC_REG_W-1:0] slc_reg;
  logic [vcvf_pkg::THR_W-1:0]     threshold;
  logic                           dim_write;

  // Clamped dimensions, registered and then staged into plane size and voxel count.
  logic [vcvf_pkg::RDIM_W-1:0] eff_rows;
  logic [vcvf_pkg::CDIM_W-1:0] eff_cols;
  logic [vcvf_pkg::SDIM_W-1:0] eff_slices;
  vcvf_pkg::dims_t             dims;
  logic [1:0]                  settle;

  // Sequencer state.
  state_t                     state;
  logic [vcvf_pkg::CNT_W-1:0] load_pos;
  logic [vcvf_pkg::CNT_W-1:0] sp;
  logic [vcvf_pkg::CNT_W-1:0] comp_vol;
  logic [vcvf_pkg::SUM_W-1:0] total_acc;
  logic [vcvf_pkg::SUM_W:0]   sum_wide;
  logic [vcvf_pkg::SUM_W-1:0] result;
  logic                       out_valid;
  vcvf_pkg::entry_t           scan;
  vcvf_pkg::entry_t           scan_next;
  logic                       scan_last;
  vcvf_pkg::entry_t           cur;
  vcvf_pkg::entry_t           nbr;
  vcvf_pkg::entry_t           nbr_q;
  logic                       nbr_ok;
  vcvf_pkg::dir_t             dir;
  logic                       in_acc;

  // Voxel memory and fill stack.
  logic                       store_mem [vcvf_pkg::VOXEL_CAP];
  logic                       store_rdata;
  logic                       st_we;
  logic                       st_re;
  logic                       st_wdata;
  logic [vcvf_pkg::IDX_W-1:0] st_waddr;
  logic [vcvf_pkg::IDX_W-1:0] st_raddr;
  vcvf_pkg::entry_t           stack_mem [vcvf_pkg::VOXEL_CAP];
  vcvf_pkg::entry_t           stack_rdata;
  logic                       stk_we;
  logic                       stk_re;
  vcvf_pkg::entry_t           stk_wdata;

  // Register writes; a dimension write restarts loading.
  assign dim_write = cfg_write &&
                     (vcvf_pkg::reg_index_t'(cfg_index) != vcvf_pkg::REG_VOLUME_THRESHOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_reg   <= vcvf_pkg::ROW_RESET;
      col_reg   <= vcvf_pkg::COL_RESET;
      slc_reg   <= vcvf_pkg::SLC_RESET;
      threshold <= vcvf_pkg::THR_RESET;
    end else if (cfg_write) begin
      case (vcvf_pkg::reg_index_t'(cfg_index))
        vcvf_pkg::REG_ROW_COUNT:        row_reg   <= cfg_data[vcvf_pkg::ROW_REG_W-1:0];
        vcvf_pkg::REG_COLUMN_COUNT:     col_reg   <= cfg_data[vcvf_pkg::COL_REG_W-1:0];
        vcvf_pkg::REG_SLICE_COUNT:      slc_reg   <= cfg_data[vcvf_pkg::SLC_REG_W-1:0];
        vcvf_pkg::REG_VOLUME_THRESHOLD: threshold <= cfg_data[vcvf_pkg::THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Zero reads as one and anything above the capacity reads as the capacity.
  always_comb begin
    if (row_reg == '0) begin
      eff_rows = vcvf_pkg::RDIM_W'(1);
    end else if (int'(row_reg) > vcvf_pkg::MAX_ROWS) begin
      eff_rows = vcvf_pkg::RDIM_W'(vcvf_pkg::MAX_ROWS);
    end else begin
      eff_rows = vcvf_pkg::RDIM_W'(row_reg);
    end
    if (col_reg == '0) begin
      eff_cols = vcvf_pkg::CDIM_W'(1);
    end else if (int'(col_reg) > vcvf_pkg::MAX_COLUMNS) begin
      eff_cols = vcvf_pkg::CDIM_W'(vcvf_pkg::MAX_COLUMNS);
    end else begin
      eff_cols = vcvf_pkg::CDIM_W'(col_reg);
    end
    if (slc_reg == '0) begin
      eff_slices = vcvf_pkg::SDIM_W'(1);
    end else if (int'(slc_reg) > vcvf_pkg::MAX_SLICES) begin
      eff_slices = vcvf_pkg::SDIM_W'(vcvf_pkg::MAX_SLICES);
    end else begin
      eff_slices = vcvf_pkg::SDIM_W'(slc_reg);
    end
  end

  // Plane size and voxel count, one multiplication per stage.
  always_ff @(posedge clk) begin
    dims.rows   <= eff_rows;
    dims.cols   <= eff_cols;
    dims.slices <= eff_slices;
    dims.plane  <= vcvf_pkg::CNT_W'(dims.rows) * vcvf_pkg::CNT_W'(dims.cols);
    dims.total  <= dims.plane * vcvf_pkg::CNT_W'(dims.slices);
  end

  // Neighbor of the popped voxel in the current direction.
  vcvf_nbr u_nbr (
    .cur  (cur),
    .dir  (dir),
    .dims (dims),
    .nbr  (nbr),
    .ok   (nbr_ok)
  );

  // Next raster position of the scan.
  always_comb begin
    scan_next     = scan;
    scan_next.idx = scan.idx + vcvf_pkg::IDX_W'(1);
    if (vcvf_pkg::CNT_W'(scan.y) + vcvf_pkg::CNT_W'(1) == vcvf_pkg::CNT_W'(dims.cols)) begin
      scan_next.y = '0;
      if (vcvf_pkg::CNT_W'(scan.x) + vcvf_pkg::CNT_W'(1) == vcvf_pkg::CNT_W'(dims.rows)) begin
        scan_next.x = '0;
        scan_next.z = scan.z + vcvf_pkg::Z_W'(1);
      end else begin
        scan_next.x = scan.x + vcvf_pkg::X_W'(1);
      end
    end else begin
      scan_next.y = scan.y + vcvf_pkg::Y_W'(1);
    end
  end

  assign scan_last = vcvf_pkg::CNT_W'(scan.idx) + vcvf_pkg::CNT_W'(1) == dims.total;
  assign sum_wide  = (vcvf_pkg::SUM_W + 1)'(total_acc) + (vcvf_pkg::SUM_W + 1)'(comp_vol);

  // Handshake ports.
  assign voxel_in.ready          = (state == ST_LOAD) && (settle == '0);
  assign in_acc                  = voxel_in.valid && voxel_in.ready;
  assign result_out.valid        = out_valid;
  assign result_out.total_volume = result;

  // Voxel memory port control: load writes, scan and probe reads, clear on push.
  always_comb begin
    st_we    = 1'b0;
    st_re    = 1'b0;
    st_wdata = 1'b0;
    st_waddr = nbr_q.idx;
    st_raddr = nbr.idx;
    case (state)
      ST_LOAD: begin
        st_we    = in_acc;
        st_wdata = voxel_in.voxel_bit;
        st_waddr = load_pos[vcvf_pkg::IDX_W-1:0];
      end
      ST_SCAN_RD: begin
        st_re    = 1'b1;
        st_raddr = scan.idx;
      end
      ST_SCAN_CHK: begin
        st_we    = store_rdata;
        st_waddr = scan.idx;
      end
      ST_PROBE: begin
        st_re = nbr_ok;
      end
      ST_TEST: begin
        st_we = store_rdata;
      end
      default: begin
      end
    endcase
  end

  // Stack port control: push on a found voxel, pop one entry per visit.
  assign stk_we    = ((state == ST_SCAN_CHK) || (state == ST_TEST)) && store_rdata;
  assign stk_wdata = (state == ST_SCAN_CHK) ? scan : nbr_q;
  assign stk_re    = (state == ST_POP);

  // Voxel memory.
  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      store_rdata <= store_mem[st_raddr];
    end
  end

  // Fill stack memory.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[sp[vcvf_pkg::IDX_W-1:0]] <= stk_wdata;
    end
    if (stk_re) begin
      stack_rdata <= stack_mem[vcvf_pkg::IDX_W'(sp - vcvf_pkg::CNT_W'(1))];
    end
  end

  // Sequencer: load, scan, flood fill and result hand-off.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      load_pos  <= '0;
      sp        <= '0;
      comp_vol  <= '0;
      total_acc <= '0;
      out_valid <= 1'b0;
      settle    <= SETTLE_CYCLES;
    end else begin
      if (cfg_write) begin
        settle <= SETTLE_CYCLES;
      end else if (settle != '0) begin
        settle <= settle - 2'd1;
      end
      // The done state sets the valid flag itself, so the clear stays out of its way.
      if (result_out.valid && result_out.ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (dim_write) begin
            load_pos <= '0;
          end else if (in_acc) begin
            if (load_pos + vcvf_pkg::CNT_W'(1) == dims.total) begin
              load_pos  <= '0;
              scan      <= '0;
              total_acc <= '0;
              state     <= ST_SCAN_RD;
            end else begin
              load_pos <= load_pos + vcvf_pkg::CNT_W'(1);
            end
          end
        end
        ST_SCAN_RD: begin
          state <= ST_SCAN_CHK;
        end
        ST_SCAN_CHK: begin
          if (store_rdata) begin
            sp       <= vcvf_pkg::CNT_W'(1);
            comp_vol <= '0;
            state    <= ST_POP;
          end else if (scan_last) begin
            state <= ST_DONE;
          end else begin
            scan  <= scan_next;
            state <= ST_SCAN_RD;
          end
        end
        ST_POP: begin
          sp       <= sp - vcvf_pkg::CNT_W'(1);
          comp_vol <= comp_vol + vcvf_pkg::CNT_W'(1);
          state    <= ST_FETCH;
        end
        ST_FETCH: begin
          cur   <= stack_rdata;
          dir   <= vcvf_pkg::DIR_Z_UP;
          state <= ST_PROBE;
        end
        ST_PROBE: begin
          if (nbr_ok) begin
            nbr_q <= nbr;
            state <= ST_TEST;
          end else if (dir == vcvf_pkg::DIR_Y_DOWN) begin
            state <= ST_AFTER;
          end else begin
            dir <= vcvf_pkg::dir_t'(dir + 3'd1);
          end
        end
        ST_TEST: begin
          if (store_rdata) begin
            sp <= sp + vcvf_pkg::CNT_W'(1);
          end
          if (dir == vcvf_pkg::DIR_Y_DOWN) begin
            state <= ST_AFTER;
          end else begin
            dir   <= vcvf_pkg::dir_t'(dir + 3'd1);
            state <= ST_PROBE;
          end
        end
        ST_AFTER: begin
          state <= (sp == '0) ? ST_COMP_END : ST_POP;
        end
        ST_COMP_END: begin
          if (vcvf_pkg::THR_W'(comp_vol) >= threshold) begin
            if (sum_wide > (vcvf_pkg::SUM_W + 1)'(vcvf_pkg::SUM_LIMIT)) begin
              total_acc <= vcvf_pkg::SUM_LIMIT;
            end else begin
              total_acc <= sum_wide[vcvf_pkg::SUM_W-1:0];
            end
          end
          if (scan_last) begin
            state <= ST_DONE;
          end else begin
            scan  <= scan_next;
            state <= ST_SCAN_RD;
          end
        end
        ST_DONE: begin
          if (!out_valid || result_out.ready) begin
            out_valid <= 1'b1;
            result    <= total_acc;
            state     <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The stack never holds more entries than the largest volume has voxels.
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= vcvf_pkg::CNT_W'(vcvf_pkg::VOXEL_CAP))
    else $error("fill stack pointer beyond capacity");

  // A new result only appears on leaving the done state.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside the done state");

  // Every finished component holds at least its seed voxel.
  a_comp_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_COMP_END |-> comp_vol != '0)
    else $error("empty component closed");

  // A register write holds off input while dimensions settle.
  a_cfg_holds_input: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> !voxel_in.ready)
    else $error("input taken right after a register write");
`endif

endmodule

// ===== tb/sv/voxel_component_volume_filter_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the voxel component volume filter: directed and random volumes.
module voxel_component_volume_filter_test;

  localparam int WATCHDOG_LIMIT = 100000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int RANDOM_WORDS   = 520;
  localparam int DIRECTED_COUNT = 8;

  // One directed volume: registers to write, voxel words to send, and a total typed in.
  typedef struct packed {
    logic [3:0]                      wr_mask;
    logic [vcvf_pkg::CFG_DATA_W-1:0] rows_val;
    logic [vcvf_pkg::CFG_DATA_W-1:0] cols_val;
    logic [vcvf_pkg::CFG_DATA_W-1:0] slices_val;
    logic [vcvf_pkg::CFG_DATA_W-1:0] thr_val;
    int                              word_count;
    logic [15:0]                     bits;
    logic                            has_total;
    logic [vcvf_pkg::SUM_W-1:0]      total;
  } volume_row_t;

  // The mask is indexed by register index: bit 0 rows, 1 columns, 2 slices, 3 threshold.
  localparam volume_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // Single voxel set, threshold still at its reset value.
    '{4'b0111, 17'd1, 17'd1, 17'd1, 17'd0, 1, 16'h0001, 1'b1, 17'd1},
    // Single voxel clear.
    '{4'b0000, 17'd0, 17'd0, 17'd0, 17'd0, 1, 16'h0000, 1'b1, 17'd0},
    // Zero dimensions act as one; threshold zero keeps two lone voxels.
    '{4'b1111, 17'd0, 17'd3, 17'd0, 17'd0, 3, 16'h0005, 1'b1, 17'd2},
    // Start a 2x2 plane, then abandon it.
    '{4'b1111, 17'd2, 17'd2, 17'd1, 17'd65536, 1, 16'h0001, 1'b0, 17'd0},
    // Rewriting a dimension restarts loading; the full plane is below the threshold.
    '{4'b0001, 17'd2, 17'd0, 17'd0, 17'd0, 4, 16'h000F, 1'b1, 17'd0},
    // Start a 1x2 row.
    '{4'b0111, 17'd1, 17'd2, 17'd1, 17'd0, 1, 16'h0001, 1'b0, 17'd0},
    // A threshold write does not restart loading.
    '{4'b1000, 17'd0, 17'd0, 17'd0, 17'd2, 1, 16'h0001, 1'b1, 17'd2},
    // Slice count above its limit acts as the limit; runs of 4, 4 and 3 along z.
    '{4'b1111, 17'd1, 17'd1, 17'd31, 17'd4, 16, 16'hEF0F, 1'b1, 17'd8}
  };

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_write;
  logic [vcvf_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [vcvf_pkg::CFG_DATA_W-1:0] cfg_data;

  vcvf_voxel_if  voxel_ch ();
  vcvf_result_if result_ch ();

  voxel_component_volume_filter i_dut (
    .clk        (clk),
    .rst        (rst),
    .voxel_in   (voxel_ch.sink),
    .result_out (result_ch.source),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Predictor state: register copies, the loaded volume and the fill stack.
  logic [vcvf_pkg::ROW_REG_W-1:0] row_reg;
  logic [vcvf_pkg::COL_REG_W-1:0] col_reg;
  logic [vcvf_pkg::SLC_REG_W-1:0] slc_reg;
  logic [vcvf_pkg::THR_W-1:0]     thr_reg;
  bit                             vox_grid [vcvf_pkg::VOXEL_CAP];
  int                             flood_stack [vcvf_pkg::VOXEL_CAP];
  int                             load_pos;
  logic [vcvf_pkg::SUM_W-1:0]     expected_totals [$];
  logic [vcvf_pkg::SUM_W-1:0]     want_total;

  // A typed total from the directed table replaces the predicted one when set.
  bit                         typed_on;
  logic [vcvf_pkg::SUM_W-1:0] typed_total;

  int errors        = 0;
  int words_sent    = 0;
  int quiet_cycles  = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;

  function automatic int clamp_dim(int v, int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic int volume_size();
    return clamp_dim(int'(row_reg), vcvf_pkg::MAX_ROWS) *
           clamp_dim(int'(col_reg), vcvf_pkg::MAX_COLUMNS) *
           clamp_dim(int'(slc_reg), vcvf_pkg::MAX_SLICES);
  endfunction

  // Flood-fills every 6-connected component and sums those at or above the threshold.
  function automatic logic [vcvf_pkg::SUM_W-1:0] sum_kept_components();
    int rows, cols, slices, voxels, kept, size, depth, idx, nidx, z, x, y, nz, nx, ny;
    rows   = clamp_dim(int'(row_reg), vcvf_pkg::MAX_ROWS);
    cols   = clamp_dim(int'(col_reg), vcvf_pkg::MAX_COLUMNS);
    slices = clamp_dim(int'(slc_reg), vcvf_pkg::MAX_SLICES);
    voxels = rows * cols * slices;
    kept   = 0;
    for (int s = 0; s < voxels; s++) begin
      if (vox_grid[s]) begin
        vox_grid[s]    = 1'b0;
        flood_stack[0] = s;
        depth          = 1;
        size           = 0;
        while (depth > 0) begin
          depth--;
          idx = flood_stack[depth];
          size++;
          y = idx % cols;
          x = (idx / cols) % rows;
          z = idx / (cols * rows);
          for (int d = 0; d < 6; d++) begin
            nz = z;
            nx = x;
            ny = y;
            case (vcvf_pkg::dir_t'(d))
              vcvf_pkg::DIR_Z_UP:   nz = z + 1;
              vcvf_pkg::DIR_Z_DOWN: nz = z - 1;
              vcvf_pkg::DIR_X_UP:   nx = x + 1;
              vcvf_pkg::DIR_X_DOWN: nx = x - 1;
              vcvf_pkg::DIR_Y_UP:   ny = y + 1;
              default:              ny = y - 1;
            endcase
            if (nz >= 0 && nx >= 0 && ny >= 0 && nz < slices && nx < rows && ny < cols) begin
              nidx = (nz * rows + nx) * cols + ny;
              // Each voxel is cleared as it is pushed, so it is counted once.
              if (vox_grid[nidx]) begin
                vox_grid[nidx]     = 1'b0;
                flood_stack[depth] = nidx;
                depth++;
              end
            end
          end
        end
        if (size >= int'(thr_reg)) begin
          kept += size;
          if (kept > int'(vcvf_pkg::SUM_LIMIT)) kept = int'(vcvf_pkg::SUM_LIMIT);
        end
      end
    end
    return vcvf_pkg::SUM_W'(kept);
  endfunction

  // Stores one voxel; the last voxel of a volume yields the expected total.
  function automatic void absorb_voxel(logic b);
    int voxels;
    voxels = volume_size();
    if (load_pos >= voxels) load_pos = 0;
    vox_grid[load_pos] = b;
    load_pos++;
    if (load_pos == voxels) begin
      load_pos = 0;
      if (typed_on) expected_totals.push_back(typed_total);
      else expected_totals.push_back(sum_kept_components());
    end
  endfunction

  // Input side: register writes and accepted voxel words feed the predictor.
  always @(posedge clk) begin
    if (rst) begin
      row_reg  = vcvf_pkg::ROW_RESET;
      col_reg  = vcvf_pkg::COL_RESET;
      slc_reg  = vcvf_pkg::SLC_RESET;
      thr_reg  = vcvf_pkg::THR_RESET;
      load_pos = 0;
    end else begin
      if (cfg_write) begin
        case (vcvf_pkg::reg_index_t'(cfg_index))
          vcvf_pkg::REG_ROW_COUNT: begin
            row_reg  = cfg_data[vcvf_pkg::ROW_REG_W-1:0];
            load_pos = 0;
          end
          vcvf_pkg::REG_COLUMN_COUNT: begin
            col_reg  = cfg_data[vcvf_pkg::COL_REG_W-1:0];
            load_pos = 0;
          end
          vcvf_pkg::REG_SLICE_COUNT: begin
            slc_reg  = cfg_data[vcvf_pkg::SLC_REG_W-1:0];
            load_pos = 0;
          end
          default: thr_reg = cfg_data[vcvf_pkg::THR_W-1:0];
        endcase
      end
      if (voxel_ch.valid && voxel_ch.ready) absorb_voxel(voxel_ch.voxel_bit);
    end
  end

  // Output side: each accepted total word is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_totals.size() == 0) begin
        errors++;
        $display("%0t: total_volume with none expected, actual %0d", $time,
                 result_ch.total_volume);
      end else begin
        want_total = expected_totals.pop_front();
        if (result_ch.total_volume !== want_total) begin
          errors++;
          $display("%0t: total_volume mismatch, expected %0d actual %0d", $time, want_total,
                   result_ch.total_volume);
        end
      end
    end
  end

  // Watchdog: ends the run when no word moves for too long.
  always @(posedge clk) begin
    if ((voxel_ch.valid && voxel_ch.ready) || (result_ch.valid && result_ch.ready) || cfg_write)
    begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d totals outstanding", $time,
               expected_totals.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver stalls at random.
  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Sends one voxel word, idling at random first; returns at the falling edge after it moved.
  task automatic send_voxel(input logic b);
    while ($urandom_range(99) < send_idle_pct) begin
      voxel_ch.valid <= 1'b0;
      @(negedge clk);
    end
    voxel_ch.valid     <= 1'b1;
    voxel_ch.voxel_bit <= b;
    @(posedge clk);
    while (!voxel_ch.ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // Holds the input until every expected total has come and the block has settled.
  task automatic wait_drained();
    voxel_ch.valid <= 1'b0;
    while (expected_totals.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input vcvf_pkg::reg_index_t r,
                           input logic [vcvf_pkg::CFG_DATA_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(negedge clk);
  endtask

  // Puts random bits above the register's own field.
  function automatic logic [vcvf_pkg::CFG_DATA_W-1:0] pad_random(int v, int w);
    logic [vcvf_pkg::CFG_DATA_W-1:0] d;
    d = vcvf_pkg::CFG_DATA_W'($urandom);
    return ((d >> w) << w) | vcvf_pkg::CFG_DATA_W'(v);
  endfunction

  function automatic int pick_small_dim(int top);
    if ($urandom_range(7) == 0) return 0;
    return $urandom_range(1, top);
  endfunction

  // At the limit or past it, up to the largest value the register holds.
  function automatic int pick_big_dim(int top, int w);
    if ($urandom_range(1) == 0) return top;
    return $urandom_range(top + 1, (1 << w) - 1);
  endfunction

  function automatic int pick_threshold();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 1;
      2, 3:    return $urandom_range(2, 6);
      4:       return $urandom_range(1, 20);
      5:       return 65536;
      6:       return (1 << vcvf_pkg::THR_W) - 1;
      default: return $urandom_range(0, (1 << vcvf_pkg::THR_W) - 1);
    endcase
  endfunction

  // Random register writes: mostly small volumes, sometimes one dimension at its extreme.
  task automatic reconfigure();
    int pick;
    bit wrote;
    wrote = 1'b0;
    if ($urandom_range(9) == 0) begin
      pick = $urandom_range(2);
      write_reg(vcvf_pkg::REG_ROW_COUNT,
                pad_random(pick == 0 ? pick_big_dim(vcvf_pkg::MAX_ROWS, vcvf_pkg::ROW_REG_W) : 1,
                           vcvf_pkg::ROW_REG_W));
      write_reg(vcvf_pkg::REG_COLUMN_COUNT,
                pad_random(pick == 1 ?
                           pick_big_dim(vcvf_pkg::MAX_COLUMNS, vcvf_pkg::COL_REG_W) : 1,
                           vcvf_pkg::COL_REG_W));
      write_reg(vcvf_pkg::REG_SLICE_COUNT,
                pad_random(pick == 2 ?
                           pick_big_dim(vcvf_pkg::MAX_SLICES, vcvf_pkg::SLC_REG_W) : 1,
                           vcvf_pkg::SLC_REG_W));
      wrote = 1'b1;
    end else begin
      if ($urandom_range(1)) begin
        write_reg(vcvf_pkg::REG_ROW_COUNT, pad_random(pick_small_dim(4), vcvf_pkg::ROW_REG_W));
        wrote = 1'b1;
      end
      if ($urandom_range(1)) begin
        write_reg(vcvf_pkg::REG_COLUMN_COUNT,
                  pad_random(pick_small_dim(6), vcvf_pkg::COL_REG_W));
        wrote = 1'b1;
      end
      if ($urandom_range(1)) begin
        write_reg(vcvf_pkg::REG_SLICE_COUNT, pad_random(pick_small_dim(3), vcvf_pkg::SLC_REG_W));
        wrote = 1'b1;
      end
    end
    if (!wrote || $urandom_range(1)) begin
      write_reg(vcvf_pkg::REG_VOLUME_THRESHOLD, vcvf_pkg::CFG_DATA_W'(pick_threshold()));
    end
    cfg_write <= 1'b0;
  endtask

  // Stimulus: directed table, then four phases of random volumes with varied idling and stalls.
  initial begin
    volume_row_t row;
    int          n;
    int          density;
    int          base;
    bit          restart_due;

    rst                = 1'b1;
    cfg_write          = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    voxel_ch.valid     = 1'b0;
    voxel_ch.voxel_bit = 1'b0;
    result_ch.ready    = 1'b0;
    typed_on           = 1'b0;
    typed_total        = '0;
    restart_due        = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed volumes, with the known totals typed in.
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.wr_mask != 4'b0000) begin
        wait_drained();
        if (row.wr_mask[vcvf_pkg::REG_ROW_COUNT]) begin
          write_reg(vcvf_pkg::REG_ROW_COUNT, row.rows_val);
        end
        if (row.wr_mask[vcvf_pkg::REG_COLUMN_COUNT]) begin
          write_reg(vcvf_pkg::REG_COLUMN_COUNT, row.cols_val);
        end
        if (row.wr_mask[vcvf_pkg::REG_SLICE_COUNT]) begin
          write_reg(vcvf_pkg::REG_SLICE_COUNT, row.slices_val);
        end
        if (row.wr_mask[vcvf_pkg::REG_VOLUME_THRESHOLD]) begin
          write_reg(vcvf_pkg::REG_VOLUME_THRESHOLD, row.thr_val);
        end
        cfg_write <= 1'b0;
      end
      typed_on    = row.has_total;
      typed_total = row.total;
      for (int k = 0; k < row.word_count; k++) send_voxel(row.bits[k]);
    end
    wait_drained();
    typed_on = 1'b0;
    base     = words_sent;

    // Random volumes, some cut short and abandoned, some sent back to back.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 56;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 56;
        end
        default: begin
          send_idle_pct = 24;
          stall_pct     = 24;
        end
      endcase
      while (words_sent < base + RANDOM_WORDS * (ph + 1) / 4) begin
        if (restart_due || $urandom_range(9) < 4) begin
          wait_drained();
          reconfigure();
        end
        n           = volume_size();
        restart_due = 1'b0;
        if (n > 1 && $urandom_range(7) == 0) begin
          n           = $urandom_range(1, n - 1);
          restart_due = 1'b1;
        end
        case ($urandom_range(9))
          0:       density = 0;
          1:       density = 100;
          default: density = $urandom_range(10, 90);
        endcase
        for (int k = 0; k < n; k++) send_voxel($urandom_range(99) < density);
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
